// ===== rtl/wtsyn_pkg.sv =====
// Wind/engine/tone synth package: command codes, Q15 constants and the small
// arithmetic helpers shared by the datapath and the port checker.
// No dependencies.
`default_nettype none

package wtsyn_pkg;

  // Command codes
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_PARAM = 2'd1;
  localparam logic [1:0] CMD_WARN  = 2'd2;
  localparam logic [1:0] CMD_STOP  = 2'd3;

  localparam int UNIT        = 32767;
  localparam int TONE_GOAL   = UNIT / 5;
  localparam int HZ_MIN      = 42;
  localparam int HZ_SPAN     = 138;
  localparam int HZ_COUNT    = HZ_SPAN + 1;
  localparam int TONE_HZ     = 720;
  localparam int RECIP_SHIFT = 18;

  localparam logic [14:0] PARAM_SLEW = 15'd96;
  localparam logic [14:0] TONE_SLEW  = 15'd128;
  localparam logic [31:0] NOISE_SEED = 32'hA51D_5EED;

  // ceil(2^18/3) and ceil(2^18/7): exact floor division for the ranges used
  localparam logic [16:0] RECIP3 = 17'd87382;
  localparam logic [15:0] RECIP7 = 16'd37450;

  // One shared multiply: operands and enable
  typedef struct packed {
    logic              en;
    logic signed [17:0] a;
    logic signed [17:0] b;
  } mul_op_t;

  function automatic logic [14:0] slew15(input logic [14:0] lvl,
                                         input logic [14:0] goal,
                                         input logic [14:0] step);
    logic [14:0] d;
    logic [14:0] res;
    res = lvl;
    if (lvl < goal) begin
      d   = goal - lvl;
      res = lvl + ((d < step) ? d : step);
    end else if (lvl > goal) begin
      d   = lvl - goal;
      res = lvl - ((d < step) ? d : step);
    end
    return res;
  endfunction

  // Triangle of the top 16 phase bits, range -32767..32767
  function automatic logic signed [15:0] tri_wave(input logic [31:0] ph);
    logic [14:0]        f;
    logic signed [16:0] t;
    f = ph[31] ? ~ph[30:16] : ph[30:16];
    t = $signed({1'b0, f, 1'b0}) - 17'sd32767;
    return t[15:0];
  endfunction

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // One-pole low-pass step; noise is the top half of the shifter, offset
  function automatic logic signed [15:0] lp_step(input logic signed [15:0] wl,
                                                 input logic [31:0] ns);
    logic signed [15:0] noise;
    logic signed [16:0] diff;
    logic signed [16:0] stp;
    logic signed [16:0] sum;
    noise = $signed({~ns[31], ns[30:16]});
    diff  = 17'(noise) - 17'(wl);
    stp   = diff[16] ? ((diff + 17'sd15) >>> 4) : (diff >>> 4);
    sum   = 17'(wl) + stp;
    return sum[15:0];
  endfunction

  // floor(m / 32767) for m < 2^30
  function automatic logic [15:0] udiv_unit(input logic [29:0] m);
    logic [15:0] q;
    logic [16:0] r;
    q = {1'b0, m[29:15]};
    r = {2'b0, m[14:0]} + {2'b0, m[29:15]};
    if (r >= 17'(UNIT)) begin
      q = q + 16'd1;
      r = r - 17'(UNIT);
    end
    if (r >= 17'(UNIT)) begin
      q = q + 16'd1;
    end
    return q;
  endfunction

  // Signed divide by 32767, truncating toward zero
  function automatic logic signed [16:0] sdiv_unit(input logic signed [35:0] p);
    logic [35:0] mag;
    logic [15:0] q;
    mag = p[35] ? 36'(-p) : 36'(p);
    q   = udiv_unit(mag[29:0]);
    return p[35] ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

endpackage

`default_nettype wire

// ===== rtl/procedural_engine_wind_tone_synth_top.sv =====
// Procedural engine / wind / warning-tone synthesizer, top level.
// Depends on wtsyn_pkg and wtsyn_mul.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//   frame tick, parameter update, warning cue or stop cue. Only a frame
//   tick produces a result; it comes out as one Q15 sample on the output
//   channel (out_valid/out_ready).
//   Parameter, warning and stop commands are registered at the transfer
//   and the block stays ready for the next command.
//   A frame tick walks an 11-step sequencer around one shared 18x18
//   multiplier: level/tone/noise update, then nine multiply steps (pitch,
//   frequency, engine amplitude, wind amplitude, tone), then the output
//   step. The sample lands in the output register at the end of that step,
//   and in_ready stays low from the tick transfer until the sequencer is
//   back in idle, so a new command is taken only once the frame is done.
//   The multiplier is the bottleneck: each product is registered before
//   the next step uses it.
//   If the receiver stalls, a finished sample holds in the output register;
//   commands that give no sample are still taken, and a new frame finishes
//   its math but waits in its last step until the register is free.
//   Reset (rst, synchronous) clears levels, goals, phases, the filter and
//   the tone, seeds the noise shifter and empties the output register.
`default_nettype none

module procedural_engine_wind_tone_synth_top
  import wtsyn_pkg::*;
#(
  parameter int SAMPLE_RATE = 48000
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        cmd,
  input  wire logic              active,
  input  wire logic [14:0]       engine_target,
  input  wire logic [14:0]       speed_norm,
  input  wire logic [14:0]       air_density,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     sample
);

  // Elaboration-time constants derived from the sample rate
  localparam logic [63:0] TONE_INC_W = (64'(TONE_HZ) << 32) / SAMPLE_RATE;
  localparam logic [31:0] TONE_INC   = TONE_INC_W[31:0];
  localparam int          TONE_LEN   = SAMPLE_RATE * 2 / 5;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SLEW, ST_PITCH, ST_HZ, ST_PHASE, ST_EA, ST_SA,
    ST_AIR, ST_W7, ST_WIND, ST_TONE, ST_DONE
  } state_t;

  state_t state;

  logic [14:0]        engine_level, engine_goal;
  logic [14:0]        speed_level, speed_goal;
  logic [14:0]        air_level, air_goal;
  logic [31:0]        engine_phase, tone_phase, noise_shift;
  logic signed [15:0] wind_lowpass;
  logic [14:0]        tone_frames_left;
  logic [12:0]        tone_level;
  logic [12:0]        eamp;      // engine_level/6 partial
  logic signed [16:0] acc;       // running sample sum

  mul_op_t            mop;
  logic signed [35:0] prod;

  // Phase increment per engine frequency, 42..180 Hz
  logic [31:0] inc_tab [HZ_COUNT];

  genvar g;
  for (g = 0; g < HZ_COUNT; g++) begin : g_inc
    localparam logic [63:0] INC = (64'(HZ_MIN + g) << 32) / SAMPLE_RATE;
    assign inc_tab[g] = INC[31:0];
  end

  wtsyn_mul u_mul (
    .clk  (clk),
    .op   (mop),
    .prod (prod)
  );

  logic               in_xfer;
  logic [16:0]        pitch_sum;
  logic [15:0]        quot;       // unsigned prod/32767
  logic [7:0]         hz_idx;
  logic [12:0]        amp;
  logic signed [15:0] tri_e, tri_t;
  logic signed [16:0] term;
  logic signed [17:0] total;
  logic signed [15:0] clamped;
  logic [14:0]        tgoal;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign pitch_sum = {1'b0, engine_level, 1'b0} + {2'b0, speed_level};
  assign quot      = udiv_unit(prod[29:0]);
  assign hz_idx    = quot[7:0];
  assign amp       = eamp + prod[30:18];
  assign tri_e     = tri_wave(engine_phase);
  assign tri_t     = tri_wave(tone_phase);
  assign term      = sdiv_unit(prod);
  assign total     = 18'(acc) + 18'(term);
  assign tgoal     = (tone_frames_left != 15'd0) ? 15'(TONE_GOAL) : 15'd0;

  always_comb begin
    if (total > 18'sd32767) begin
      clamped = 16'sd32767;
    end else if (total < -18'sd32767) begin
      clamped = -16'sd32767;
    end else begin
      clamped = total[15:0];
    end
  end

  // Operand select for the shared multiplier
  always_comb begin
    mop.en = 1'b1;
    mop.a  = '0;
    mop.b  = '0;
    case (state)
      ST_PITCH: begin
        mop.a = $signed({1'b0, pitch_sum});
        mop.b = $signed({1'b0, RECIP3});
      end
      ST_HZ: begin
        mop.a = $signed({3'b0, prod[32:18]});
        mop.b = 18'(HZ_SPAN);
      end
      ST_PHASE: begin
        mop.a = $signed({4'b0, engine_level[14:1]});
        mop.b = $signed({1'b0, RECIP3});
      end
      ST_EA: begin
        mop.a = $signed({5'b0, speed_level[14:2]});
        mop.b = $signed({1'b0, RECIP3});
      end
      ST_SA: begin
        mop.a = 18'(tri_e);
        mop.b = $signed({5'b0, amp});
      end
      ST_AIR: begin
        mop.a = $signed({3'b0, air_level});
        mop.b = $signed({3'b0, speed_level});
      end
      ST_W7: begin
        mop.a = $signed({2'b0, quot});
        mop.b = $signed({2'b0, RECIP7});
      end
      ST_WIND: begin
        mop.a = 18'(wind_lowpass);
        mop.b = $signed({5'b0, prod[30:18]});
      end
      ST_TONE: begin
        mop.a = 18'(tri_t);
        mop.b = $signed({5'b0, tone_level});
      end
      default: begin
        mop.en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      engine_level     <= '0;
      engine_goal      <= '0;
      speed_level      <= '0;
      speed_goal       <= '0;
      air_level        <= '0;
      air_goal         <= '0;
      engine_phase     <= '0;
      tone_phase       <= '0;
      noise_shift      <= NOISE_SEED;
      wind_lowpass     <= '0;
      tone_frames_left <= '0;
      tone_level       <= '0;
    end else begin
      // ST_DONE handles its own output transfer
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (cmd)
              CMD_FRAME: begin
                state <= ST_SLEW;
              end
              CMD_PARAM: begin
                engine_goal <= active ? engine_target : 15'd0;
                speed_goal  <= active ? speed_norm : 15'd0;
                air_goal    <= active ? air_density : 15'd0;
              end
              CMD_WARN: begin
                tone_frames_left <= 15'(TONE_LEN);
              end
              default: begin
                engine_goal      <= '0;
                speed_goal       <= '0;
                air_goal         <= '0;
                tone_frames_left <= '0;
              end
            endcase
          end
        end
        ST_SLEW: begin
          // everything that needs no multiply
          engine_level <= slew15(engine_level, engine_goal, PARAM_SLEW);
          speed_level  <= slew15(speed_level, speed_goal, PARAM_SLEW);
          air_level    <= slew15(air_level, air_goal, PARAM_SLEW);
          noise_shift  <= xorshift32(noise_shift);
          wind_lowpass <= lp_step(wind_lowpass, xorshift32(noise_shift));
          tone_level   <= 13'(slew15({2'b0, tone_level}, tgoal, TONE_SLEW));
          if (tone_frames_left != 15'd0) begin
            tone_frames_left <= tone_frames_left - 15'd1;
          end
          tone_phase <= tone_phase + TONE_INC;
          state      <= ST_PITCH;
        end
        ST_PITCH: state <= ST_HZ;
        ST_HZ:    state <= ST_PHASE;
        ST_PHASE: begin
          engine_phase <= engine_phase + inc_tab[hz_idx];
          state        <= ST_EA;
        end
        ST_EA: begin
          eamp  <= prod[30:18];
          state <= ST_SA;
        end
        ST_SA: state <= ST_AIR;
        ST_AIR: begin
          acc   <= term;
          state <= ST_W7;
        end
        ST_W7:   state <= ST_WIND;
        ST_WIND: state <= ST_TONE;
        ST_TONE: begin
          acc   <= total[16:0];
          state <= ST_DONE;
        end
        ST_DONE: begin
          // hold here until the output register is free
          if (!out_valid || out_ready) begin
            sample    <= clamped;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wtsyn_mul.sv =====
// Shared signed 18x18 multiplier with registered product.
// Depends on wtsyn_pkg (mul_op_t).
`default_nettype none

module wtsyn_mul
  import wtsyn_pkg::*;
(
  input  wire logic               clk,
  input  wire mul_op_t            op,
  output logic signed [35:0]      prod
);

  always_ff @(posedge clk) begin
    if (op.en) begin
      prod <= $signed(op.a) * $signed(op.b);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wtsyn_chk.sv =====
// Port-level checker for the synth top, attached by bind.
// Depends on wtsyn_pkg (command codes).
`default_nettype none

module wtsyn_chk
  import wtsyn_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic [1:0]        cmd,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic signed [15:0] sample
);

  // Clamp keeps the sample symmetric
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sample != 16'sh8000))
    else $error("sample outside +-32767");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(sample)))
    else $error("stalled sample changed");

  // A frame tick keeps the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && cmd == CMD_FRAME) |=> !in_ready)
    else $error("ready right after frame tick");

  // Nothing is produced right after a transfer into an empty output
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared without sequencer work");

endmodule

bind procedural_engine_wind_tone_synth_top wtsyn_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .sample    (sample)
);

`default_nettype wire
